// ===== design/partition_quorum_fsm_top_defines.svh =====
// Assertion helpers used by pqf_core.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef PARTITION_QUORUM_FSM_TOP_DEFINES_SVH
`define PARTITION_QUORUM_FSM_TOP_DEFINES_SVH

// Same-cycle implication
`define PQF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PQF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pqf_pkg.sv =====
package pqf_pkg;

	// Field widths
	localparam int TOTAL_W    = 11;
	localparam int EPOCH_W    = 32;
	localparam int TIME_W     = 64;
	localparam int FACTOR_W   = 17;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Ramp arithmetic: elapsed times past RAMP_SAT_US always saturate, so the
	// multiplier only sees the low ELAPSED_W bits.
	localparam int ELAPSED_W   = 36;
	localparam int PROD_W      = FACTOR_W + ELAPSED_W;
	localparam int HALF_W      = 18;
	localparam int RECIP_W     = 37;
	localparam int PART_W      = HALF_W + RECIP_W;
	localparam int ACC_W       = PART_W + HALF_W;
	localparam int RECIP_SHIFT = 56;

	localparam logic [FACTOR_W-1:0]  FIXED_ONE     = 17'd65536;
	localparam logic [TOTAL_W-1:0]   MAX_MODULES   = 11'd1024;
	localparam logic [TIME_W-1:0]    RAMP_SAT_US   = 64'd65536000000;
	localparam logic [PROD_W-1:0]    RAMP_SAT_PROD = 53'd65536000000;
	// ceil(2^56 / 1e6): exact quotient by one million for 36-bit dividends
	localparam logic [RECIP_W-1:0]   RECIP_M       = 37'd72057594038;

	// Reset values of the registers
	localparam logic [TOTAL_W-1:0]    RST_TOTAL    = 11'd16;
	localparam logic [31:0]           RST_CONFIRM  = 32'd500000;
	localparam logic [31:0]           RST_RECOVERY = 32'd30000000;
	localparam logic [FACTOR_W-1:0]   RST_RATE     = 17'd6554;
	localparam logic [EPOCH_W-1:0]    RST_EPOCH    = 32'd1;

	typedef enum logic [2:0] {
		MODE_HEALTHY = 3'd0,
		MODE_SUSPECT = 3'd1,
		MODE_MAJOR   = 3'd2,
		MODE_MINOR   = 3'd3,
		MODE_RECON   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_VISIBLE = 2'd1,
		REQ_EPOCH   = 2'd2,
		REQ_SYNC    = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL     = 2'd0,
		CFG_CONFIRM   = 2'd1,
		CFG_RECOVERY  = 2'd2,
		CFG_RAMP_RATE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [31:0]         confirm_us;
		logic [31:0]         recovery_us;
		logic [FACTOR_W-1:0] rate;
	} cfg_t;

	// Re-initialization strobe from a cluster size write
	typedef struct packed {
		logic               valid;
		logic [TOTAL_W-1:0] total;
	} init_t;

	typedef struct packed {
		logic                 start;
		logic                 clear;
		logic [FACTOR_W-1:0]  rate;
		logic [ELAPSED_W-1:0] elapsed;
	} mul_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [FACTOR_W-1:0] inc;
	} mul_rsp_t;

endpackage

// ===== design/pqf_ifs.sv =====
// Event request channel
interface pqf_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] now_us;
	logic [10:0] visible;
	logic [31:0] peer_epoch;

	modport source (output valid, req_type, now_us, visible, peer_epoch, input ready);
	modport sink (input valid, req_type, now_us, visible, peer_epoch, output ready);
endinterface

// Status result channel
interface pqf_stat_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] epoch;
	logic [16:0] power_factor;
	logic        can_vote;
	logic        can_elect;
	logic        freeze;

	modport source (output valid, mode, epoch, power_factor, can_vote, can_elect, freeze,
		input ready);
	modport sink (input valid, mode, epoch, power_factor, can_vote, can_elect, freeze,
		output ready);
endinterface

// ===== design/pqf_ramp_mul.sv =====
// Ramp increment: min(rate * elapsed / 1e6, one), through operand, product, partial-product and result registers.
module pqf_ramp_mul import pqf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic                 v_s1, v_s2, v_s3, done_q;
	logic [FACTOR_W-1:0]  rate_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [PROD_W-1:0]    prod_s2;
	logic                 sat_s3;
	logic [PART_W-1:0]    lo_s3, hi_s3;
	logic [ACC_W-1:0]     acc;
	logic [FACTOR_W-1:0]  inc_q;

	// Stage valids; the result flag stays up until the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				done_q <= 1'b1;
			end else if (req.clear) begin
				done_q <= 1'b0;
			end
		end
	end

	// Partial products recombined: quotient is the top bits of prod * RECIP_M
	assign acc = {hi_s3, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_s3};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rate_s1    <= req.rate;
			elapsed_s1 <= req.elapsed;
		end
		if (v_s1) begin
			prod_s2 <= PROD_W'(rate_s1) * PROD_W'(elapsed_s1);
		end
		if (v_s2) begin
			sat_s3 <= (prod_s2 >= RAMP_SAT_PROD);
			lo_s3  <= PART_W'(prod_s2[HALF_W-1:0]) * PART_W'(RECIP_M);
			hi_s3  <= PART_W'(prod_s2[2*HALF_W-1:HALF_W]) * PART_W'(RECIP_M);
		end
		if (v_s3) begin
			inc_q <= sat_s3 ? FIXED_ONE : acc[RECIP_SHIFT+FACTOR_W-1:RECIP_SHIFT];
		end
	end

	assign rsp.busy = v_s1 | v_s2 | v_s3;
	assign rsp.done = done_q;
	assign rsp.inc  = inc_q;

endmodule

// ===== design/pqf_core.sv =====
`include "partition_quorum_fsm_top_defines.svh"

// Input register, mode state, next-state logic and result register.
module pqf_core import pqf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  init_t init,
	pqf_evt_if.sink    evt,
	pqf_stat_if.source stat
);

	// Input register
	logic                valid_s1;
	logic [1:0]          req_type_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [TOTAL_W-1:0]  visible_s1;
	logic [EPOCH_W-1:0]  repoch_s1;

	// Monitor state
	mode_t               mode_q;
	logic [EPOCH_W-1:0]  epoch_q, max_epoch_q;
	logic [TOTAL_W-1:0]  visible_q;
	logic [TIME_W-1:0]   entered_q, last_tick_q;
	logic [FACTOR_W-1:0] ramp_q;
	logic                sync_q;

	// Result register
	logic                res_valid_q;
	logic [2:0]          res_mode_q;
	logic [EPOCH_W-1:0]  res_epoch_q;
	logic [FACTOR_W-1:0] res_power_q;
	logic                res_vote_q, res_elect_q, res_freeze_q;

	// Next state
	mode_t               mode_nxt, tgt;
	logic [EPOCH_W-1:0]  epoch_nxt, max_epoch_nxt;
	logic [TOTAL_W-1:0]  visible_nxt;
	logic [TIME_W-1:0]   entered_nxt, last_tick_nxt;
	logic [FACTOR_W-1:0] ramp_nxt, ramp_adv, power;
	logic                sync_nxt;

	logic [TIME_W-1:0]   elapsed, in_state;
	logic [TOTAL_W-1:0]  quorum;
	logic [FACTOR_W:0]   ramp_sum;
	logic                out_free, ramp_live, rate_nz, elapsed_big, slow, done, timeout;

	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;

	pqf_ramp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Handshake and ramp-unit control
	assign out_free    = !res_valid_q || stat.ready;
	assign elapsed     = now_s1 - last_tick_q;
	assign in_state    = now_s1 - entered_q;
	assign quorum      = (cfg.total >> 1) + TOTAL_W'(1);
	assign ramp_live   = (ramp_q < FIXED_ONE);
	assign rate_nz     = (cfg.rate != '0);
	assign elapsed_big = (elapsed >= RAMP_SAT_US);
	assign slow        = valid_s1 && (req_type_s1 == REQ_TICK) && (mode_q == MODE_RECON) &&
		ramp_live && rate_nz && !elapsed_big;
	assign done        = valid_s1 && out_free && (!slow || mul_rsp.done);
	assign evt.ready   = !valid_s1 || done;

	assign mul_req.start   = slow && !mul_rsp.busy && !mul_rsp.done;
	assign mul_req.clear   = done && slow;
	assign mul_req.rate    = cfg.rate;
	assign mul_req.elapsed = elapsed[ELAPSED_W-1:0];

	// Ramp advance for a reconciling tick
	assign ramp_sum = {1'b0, ramp_q} + {1'b0, mul_rsp.inc};
	always_comb begin
		if (!ramp_live) begin
			ramp_adv = FIXED_ONE;
		end else if (!rate_nz) begin
			ramp_adv = ramp_q;
		end else if (elapsed_big || ramp_sum > {1'b0, FIXED_ONE}) begin
			ramp_adv = FIXED_ONE;
		end else begin
			ramp_adv = ramp_sum[FACTOR_W-1:0];
		end
	end

	assign timeout = (in_state >= {32'd0, cfg.recovery_us});

	// Next state for the item in the input register
	always_comb begin
		tgt           = mode_q;
		mode_nxt      = mode_q;
		epoch_nxt     = epoch_q;
		max_epoch_nxt = max_epoch_q;
		visible_nxt   = visible_q;
		entered_nxt   = entered_q;
		last_tick_nxt = last_tick_q;
		ramp_nxt      = ramp_q;
		sync_nxt      = sync_q;
		case (req_type_s1)
			REQ_TICK: begin
				last_tick_nxt = now_s1;
				case (mode_q)
					MODE_HEALTHY: begin
						if (visible_q < quorum) tgt = MODE_SUSPECT;
					end
					MODE_SUSPECT: begin
						if (in_state >= {32'd0, cfg.confirm_us}) begin
							tgt = (visible_q >= quorum) ? MODE_MAJOR : MODE_MINOR;
						end else if (visible_q >= quorum) begin
							tgt = MODE_HEALTHY;
						end
					end
					MODE_MAJOR: begin
						if (visible_q >= cfg.total) begin
							tgt = MODE_HEALTHY;
						end else if (visible_q < quorum) begin
							tgt = MODE_SUSPECT;
						end
					end
					MODE_MINOR: begin
						if (max_epoch_q > epoch_q) tgt = MODE_RECON;
					end
					MODE_RECON: begin
						ramp_nxt = ramp_adv;
						// sync done with full power, or recovery limit reached
						if ((sync_q && ramp_adv == FIXED_ONE) || timeout) begin
							if (max_epoch_q > epoch_q) epoch_nxt = max_epoch_q;
							tgt = MODE_HEALTHY;
						end
						if (timeout) sync_nxt = 1'b1;
					end
					default: begin
					end
				endcase
				// Mode entry actions
				if (tgt != mode_q) begin
					mode_nxt    = tgt;
					entered_nxt = now_s1;
					case (tgt)
						MODE_HEALTHY: ramp_nxt = FIXED_ONE;
						MODE_MAJOR: begin
							epoch_nxt = epoch_q + EPOCH_W'(1);
							ramp_nxt  = FIXED_ONE;
						end
						MODE_MINOR: ramp_nxt = '0;
						MODE_RECON: begin
							ramp_nxt = '0;
							sync_nxt = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			REQ_VISIBLE: visible_nxt = visible_s1;
			REQ_EPOCH: begin
				if (repoch_s1 > max_epoch_q) max_epoch_nxt = repoch_s1;
			end
			REQ_SYNC: begin
				if (mode_q == MODE_RECON) sync_nxt = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Power reported for the mode after the event
	always_comb begin
		case (mode_nxt)
			MODE_MINOR: power = '0;
			MODE_RECON: power = ramp_nxt;
			default:    power = FIXED_ONE;
		endcase
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			req_type_s1 <= evt.req_type;
			now_s1      <= evt.now_us;
			visible_s1  <= evt.visible;
			repoch_s1   <= evt.peer_epoch;
		end
	end

	// Monitor state; a cluster size write re-initializes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HEALTHY;
			epoch_q     <= RST_EPOCH;
			max_epoch_q <= RST_EPOCH;
			visible_q   <= RST_TOTAL;
			entered_q   <= '0;
			last_tick_q <= '0;
			ramp_q      <= FIXED_ONE;
			sync_q      <= 1'b0;
		end else if (init.valid) begin
			mode_q      <= MODE_HEALTHY;
			epoch_q     <= RST_EPOCH;
			max_epoch_q <= RST_EPOCH;
			visible_q   <= init.total;
			entered_q   <= '0;
			last_tick_q <= '0;
			ramp_q      <= FIXED_ONE;
			sync_q      <= 1'b0;
		end else if (done) begin
			mode_q      <= mode_nxt;
			epoch_q     <= epoch_nxt;
			max_epoch_q <= max_epoch_nxt;
			visible_q   <= visible_nxt;
			entered_q   <= entered_nxt;
			last_tick_q <= last_tick_nxt;
			ramp_q      <= ramp_nxt;
			sync_q      <= sync_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (stat.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_mode_q   <= mode_nxt;
			res_epoch_q  <= epoch_nxt;
			res_power_q  <= power;
			res_vote_q   <= (mode_nxt == MODE_HEALTHY) || (mode_nxt == MODE_SUSPECT) ||
				(mode_nxt == MODE_MAJOR);
			res_elect_q  <= (mode_nxt == MODE_HEALTHY) || (mode_nxt == MODE_MAJOR);
			res_freeze_q <= (mode_nxt == MODE_MINOR);
		end
	end

	assign stat.valid        = res_valid_q;
	assign stat.mode         = res_mode_q;
	assign stat.epoch        = res_epoch_q;
	assign stat.power_factor = res_power_q;
	assign stat.can_vote     = res_vote_q;
	assign stat.can_elect    = res_elect_q;
	assign stat.freeze       = res_freeze_q;

	// Power follows the mode; the ramp never passes one
	`PQF_ASSERT(a_minor_zero, mode_q == MODE_MINOR, ramp_q == '0, "ramp not zero in minority")
	`PQF_ASSERT(a_full_power, mode_q < MODE_MINOR, ramp_q == FIXED_ONE, "ramp not one at full power")
	`PQF_ASSERT(a_ramp_cap, 1'b1, ramp_q <= FIXED_ONE, "ramp above one")
	// A ramp result is held until the waiting tick completes
	`PQF_ASSERT_NEXT(a_mul_hold, mul_rsp.done && !mul_req.clear, mul_rsp.done, "ramp result lost")
	`PQF_ASSERT(a_slow_stall, slow && !mul_rsp.done, !evt.ready, "request taken during ramp math")

endmodule

// ===== design/partition_quorum_fsm_top.sv =====
// Quorum partition monitor.
// Requests arrive on evt (valid/ready): a tick with now_us, a visible-module
// count, a remote epoch, or a sync notice, chosen by req_type. Every request
// yields one status on stat (valid/ready): mode, local epoch, unsigned Q1.16 power
// factor and the vote/elect/freeze flags after that request.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no request is in flight, which the block does not
// enforce. Writing a nonzero cluster size re-initializes the state.
// Throughput is one request per cycle while stat is taken; a tick in
// reconciling that advances a partial ramp holds the input while the
// ramp unit forms rate * elapsed / 1e6 (operand, product, two partial
// products against a reciprocal, recombine).
// A stalled stat.ready keeps one finished status and one accepted request;
// evt.ready then drops until the status is taken.
// arst_n clears everything to healthy, epoch one, full power, and loads the
// register reset values (16 modules, 0.5 s confirm, 30 s recovery).
module partition_quorum_fsm_top import pqf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pqf_evt_if.sink               evt,
	pqf_stat_if.source            stat
);

	cfg_t               cfg_q;
	init_t              init;
	logic [TOTAL_W-1:0] wr_total, wr_clamped;

	// Cluster size write: zero is ignored, oversize saturates
	assign wr_total   = cfg_data[TOTAL_W-1:0];
	assign wr_clamped = (wr_total > MAX_MODULES) ? MAX_MODULES : wr_total;
	assign init.valid = cfg_we && (cfg_index == CFG_TOTAL) && (wr_total != '0);
	assign init.total = wr_clamped;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total       <= RST_TOTAL;
			cfg_q.confirm_us  <= RST_CONFIRM;
			cfg_q.recovery_us <= RST_RECOVERY;
			cfg_q.rate        <= RST_RATE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TOTAL: begin
					if (init.valid) cfg_q.total <= wr_clamped;
				end
				CFG_CONFIRM:   cfg_q.confirm_us  <= cfg_data;
				CFG_RECOVERY:  cfg_q.recovery_us <= cfg_data;
				CFG_RAMP_RATE: cfg_q.rate        <= cfg_data[FACTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pqf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.init   (init),
		.evt    (evt),
		.stat   (stat)
	);

endmodule
